FILE: sv/tths_pkg.sv
// Shared types and constants of the tiled texture height sampler.
package tths_pkg;

  localparam int COORD_W    = 17;
  localparam int TILE_W     = 21;
  localparam int SIDE_W     = 9;
  localparam int IDX_W      = 16;
  localparam int WORD_W     = 32;
  localparam int HGT_W      = 16;
  localparam int LIN_W      = 18;  // y * w + x, sides at most 511
  localparam int FRAC_W     = 32;  // wrapped coordinate, Q32
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam int CS_W       = 3;
  localparam int LUM_W      = 22;  // weighted sum, at most 255 * 10000
  localparam int NUM_W      = 30;  // 257 * sum + rounding term

  localparam logic [COORD_W:0]  HALF_Q16 = 18'd32768;
  localparam logic [FRAC_W-1:0] HALF_Q32 = 32'h8000_0000;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic FMT_GRAY = 1'b0;
  localparam logic FMT_BGRA = 1'b1;

  localparam logic [CS_W-1:0] CS_RED   = 3'd0;
  localparam logic [CS_W-1:0] CS_GREEN = 3'd1;
  localparam logic [CS_W-1:0] CS_BLUE  = 3'd2;
  localparam logic [CS_W-1:0] CS_ALPHA = 3'd3;
  localparam logic [CS_W-1:0] CS_LUMA  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SELECT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILING_U       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TILING_V       = 3'd5;

  // Rec.709 weights in units of 1/10000
  localparam logic [13:0] LUM_KR = 14'd2126;
  localparam logic [13:0] LUM_KG = 14'd7152;
  localparam logic [13:0] LUM_KB = 14'd722;
  localparam logic [8:0]  LUM_SCALE = 9'd257;
  localparam logic [12:0] LUM_ROUND = 13'd5000;
  // floor(n / 10000) == (n * DIV_MAGIC) >> DIV_SHIFT, exact for n < 2^30
  localparam logic [NUM_W-1:0] DIV_MAGIC = 30'd879609303;
  localparam int DIV_SHIFT = 43;

  typedef struct packed {
    logic              valid;
    logic              is_load;
    logic [IDX_W-1:0]  pixel_index;
    logic [WORD_W-1:0] texel_word;
  } tag_t;

  typedef struct packed {
    logic valid;  // sample item in stage
    logic ok;     // sample yields a height
  } shd_ctl_t;

  typedef struct packed {
    logic             valid;
    logic             sample_valid;
    logic [HGT_W-1:0] height_value;
  } result_t;

endpackage

FILE: sv/tths_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tths_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/tths_coord.sv
// Coordinate pipeline: tile and wrap, pixel rounding, linear address, store wrap.
module tths_coord #(
  parameter int STORE_DEPTH = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  tths_pkg::tag_t                      tag_in,
  input  logic [tths_pkg::COORD_W-1:0]        coord_u,
  input  logic [tths_pkg::COORD_W-1:0]        coord_v,
  input  logic signed [tths_pkg::TILE_W-1:0]  tiling_u,
  input  logic signed [tths_pkg::TILE_W-1:0]  tiling_v,
  input  logic [tths_pkg::SIDE_W-1:0]         side_w,
  input  logic [tths_pkg::SIDE_W-1:0]         side_h,
  output tths_pkg::tag_t                      tag_out,
  output logic [$clog2(STORE_DEPTH)-1:0]      addr
);
  import tths_pkg::*;

  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int DEP_W  = $clog2(STORE_DEPTH + 1);
  localparam int RCP_SH = 36;
  localparam longint unsigned RECIP = (64'd1 << RCP_SH) / STORE_DEPTH;
  localparam int QP_W   = RCP_SH + LIN_W;
  localparam int QD_W   = LIN_W + DEP_W;
  localparam int CMP_W  = (DEP_W > LIN_W) ? DEP_W : LIN_W;
  localparam int EXT_W  = (AW > LIN_W) ? AW : LIN_W;
  localparam int XP_W   = FRAC_W + SIDE_W;
  localparam int YP_W   = FRAC_W + SIDE_W + 1;

  tag_t c1_tag_r, c2_tag_r, c3_tag_r, c4_tag_r, c5_tag_r;

  // stage 1: (c - 0.5) * tiling + 0.5, keep the Q32 fraction
  logic signed [COORD_W:0]        du, dv;
  logic signed [COORD_W+TILE_W:0] mu, mv;
  logic [FRAC_W-1:0]              fu_nxt, fv_nxt, fu_r, fv_r;

  assign du = $signed({1'b0, coord_u}) - $signed(HALF_Q16);
  assign dv = $signed({1'b0, coord_v}) - $signed(HALF_Q16);
  assign mu = du * tiling_u;
  assign mv = dv * tiling_v;
  assign fu_nxt = mu[FRAC_W-1:0] + HALF_Q32;
  assign fv_nxt = mv[FRAC_W-1:0] + HALF_Q32;

  // stage 2: round half up onto the pixel grid, v flipped
  logic [SIDE_W-1:0] span_w, span_h, x_raw, x_nxt, y_nxt, x_r, y_r;
  logic [XP_W-1:0]   xp, xr;
  logic [FRAC_W:0]   fv_inv;
  logic [YP_W-1:0]   yp, yr;
  logic [SIDE_W:0]   y_raw;

  assign span_w = side_w - 9'd1;
  assign span_h = side_h - 9'd1;
  assign xp     = XP_W'(fu_r) * XP_W'(span_w);
  assign xr     = xp + XP_W'(HALF_Q32);
  assign x_raw  = xr[FRAC_W +: SIDE_W];
  assign x_nxt  = (x_raw > span_w) ? span_w : x_raw;
  assign fv_inv = {1'b1, {FRAC_W{1'b0}}} - {1'b0, fv_r};
  assign yp     = YP_W'(fv_inv) * YP_W'(span_h);
  assign yr     = yp + YP_W'(HALF_Q32);
  assign y_raw  = yr[FRAC_W +: SIDE_W+1];
  assign y_nxt  = (y_raw > {1'b0, span_h}) ? span_h : y_raw[SIDE_W-1:0];

  // stage 3: row-major address
  logic [LIN_W-1:0] lin_nxt, lin_r;
  assign lin_nxt = LIN_W'(y_r) * LIN_W'(side_w) + LIN_W'(x_r);

  // stage 4: quotient estimate by reciprocal, low by at most one
  logic [QP_W-1:0]  qp;
  logic [LIN_W-1:0] qe_nxt, qe_r, lin4_r;
  assign qp     = QP_W'(lin_r) * QP_W'(RECIP);
  assign qe_nxt = qp[RCP_SH +: LIN_W];

  // stage 5: partial remainder, below twice the depth
  logic [QD_W-1:0]  qd;
  logic [LIN_W-1:0] r1_nxt, r1_r;
  assign qd     = QD_W'(qe_r) * QD_W'(STORE_DEPTH);
  assign r1_nxt = lin4_r - qd[LIN_W-1:0];

  // final correction feeds the RAM address
  logic [CMP_W-1:0] diff;
  logic             geq;
  logic [LIN_W-1:0] rr;
  logic [EXT_W-1:0] r_ext;
  assign diff  = CMP_W'(r1_r) - CMP_W'(STORE_DEPTH);
  assign geq   = CMP_W'(r1_r) >= CMP_W'(STORE_DEPTH);
  assign rr    = geq ? diff[LIN_W-1:0] : r1_r;
  assign r_ext = EXT_W'(rr);
  assign addr  = r_ext[AW-1:0];
  assign tag_out = c5_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_tag_r.valid <= 1'b0;
      c2_tag_r.valid <= 1'b0;
      c3_tag_r.valid <= 1'b0;
      c4_tag_r.valid <= 1'b0;
      c5_tag_r.valid <= 1'b0;
    end else if (adv) begin
      c1_tag_r <= tag_in;
      c2_tag_r <= c1_tag_r;
      c3_tag_r <= c2_tag_r;
      c4_tag_r <= c3_tag_r;
      c5_tag_r <= c4_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fu_r   <= fu_nxt;
      fv_r   <= fv_nxt;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      lin_r  <= lin_nxt;
      qe_r   <= qe_nxt;
      lin4_r <= lin_r;
      r1_r   <= r1_nxt;
    end
  end

endmodule

FILE: sv/tths_shade.sv
// Texel to height: channel pick or Rec.709 luminance, scaled to Q16.
module tths_shade (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  tths_pkg::shd_ctl_t          ctl,
  input  logic [tths_pkg::WORD_W-1:0] texel,
  input  logic                        pixel_format,
  input  logic [tths_pkg::CS_W-1:0]   channel_select,
  output tths_pkg::result_t           res
);
  import tths_pkg::*;

  localparam int DP_W = 2 * NUM_W;

  logic [7:0] b, g, r, a;
  assign b = texel[7:0];
  assign g = texel[15:8];
  assign r = texel[23:16];
  assign a = texel[31:24];

  // stage 1: select byte, weighted sum
  logic             lum_nxt;
  logic [7:0]       byte_nxt;
  logic [LUM_W-1:0] s_nxt;

  assign lum_nxt = (pixel_format == FMT_BGRA) && (channel_select == CS_LUMA);
  assign s_nxt   = LUM_W'(r) * LUM_W'(LUM_KR) + LUM_W'(g) * LUM_W'(LUM_KG)
                 + LUM_W'(b) * LUM_W'(LUM_KB);

  always_comb begin
    byte_nxt = 8'd0;
    if (pixel_format == FMT_GRAY) begin
      byte_nxt = b;
    end else begin
      case (channel_select)
        CS_RED:   byte_nxt = r;
        CS_GREEN: byte_nxt = g;
        CS_BLUE:  byte_nxt = b;
        CS_ALPHA: byte_nxt = a;
        default:  byte_nxt = 8'd0;
      endcase
    end
  end

  shd_ctl_t         h1_ctl_r, h2_ctl_r, h3_ctl_r;
  logic             h1_lum_r, h2_lum_r, h3_lum_r;
  logic [7:0]       h1_byte_r, h2_byte_r, h3_byte_r;
  logic [LUM_W-1:0] s_r;

  // stage 2: 257 * s + 5000
  logic [NUM_W-1:0] n_nxt, n_r;
  assign n_nxt = NUM_W'(s_r) * NUM_W'(LUM_SCALE) + NUM_W'(LUM_ROUND);

  // stage 3: divide by 10000 through the reciprocal
  logic [DP_W-1:0]  dp;
  logic [HGT_W-1:0] q_nxt, q_r;
  assign dp    = DP_W'(n_r) * DP_W'(DIV_MAGIC);
  assign q_nxt = dp[DIV_SHIFT +: HGT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_ctl_r.valid <= 1'b0;
      h2_ctl_r.valid <= 1'b0;
      h3_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      h1_ctl_r <= ctl;
      h2_ctl_r <= h1_ctl_r;
      h3_ctl_r <= h2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h1_lum_r  <= lum_nxt;
      h1_byte_r <= byte_nxt;
      s_r       <= s_nxt;
      h2_lum_r  <= h1_lum_r;
      h2_byte_r <= h1_byte_r;
      n_r       <= n_nxt;
      h3_lum_r  <= h2_lum_r;
      h3_byte_r <= h2_byte_r;
      q_r       <= q_nxt;
    end
  end

  // byte * 257 is the byte repeated
  always_comb begin
    res.valid        = h3_ctl_r.valid;
    res.sample_valid = h3_ctl_r.ok;
    if (!h3_ctl_r.ok) begin
      res.height_value = '0;
    end else if (h3_lum_r) begin
      res.height_value = q_r;
    end else begin
      res.height_value = {h3_byte_r, h3_byte_r};
    end
  end

endmodule

FILE: sv/tiled_texture_height_sampler_core.sv
// Top level of the tiled nearest-neighbor texture height sampler.
//
//   channel | signals                                       | role
//   --------+-----------------------------------------------+--------------------------------
//   in      | in_valid/in_ready, in_func, in_pixel_index,   | load one texel word, or sample
//           | in_texel_word, in_coord_u, in_coord_v         | at Q16 (u, v)
//   out     | out_valid/out_ready, out_height_value,        | one item per sample, none per
//           | out_sample_valid                              | load
//   cfg     | cfg_we, cfg_index, cfg_data                   | register write, no wait
//
// One item per cycle sustained while the output is not held; a sample passes
// through 5 coordinate stages, the texel RAM read, 3 shading stages and the
// output register. The texel RAM sets the order: loads and samples write
// and read it in the same stage, so a sample sees exactly the loads
// accepted before it.
// Reset clears valid bits, the loaded flag and the registers; the texel store
// is not cleared and is ready at once.
// All stages advance together whenever the output register is empty or being
// taken; a held output freezes the whole pipe and in_ready drops.
module tiled_texture_height_sampler_core #(
  parameter int MAX_SIDE    = 256,
  parameter int STORE_DEPTH = 65536
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic [tths_pkg::IDX_W-1:0]      in_pixel_index,
  input  logic [tths_pkg::WORD_W-1:0]     in_texel_word,
  input  logic [tths_pkg::COORD_W-1:0]    in_coord_u,
  input  logic [tths_pkg::COORD_W-1:0]    in_coord_v,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tths_pkg::HGT_W-1:0]      out_height_value,
  output logic                            out_sample_valid,
  // configuration
  input  logic                            cfg_we,
  input  logic [tths_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tths_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tths_pkg::*;

  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int DEP_W  = $clog2(STORE_DEPTH + 1);
  localparam int MS_W   = $clog2(MAX_SIDE + 1);
  localparam int SCMP_W = (MS_W > SIDE_W) ? MS_W : SIDE_W;
  localparam int ICMP_W = (DEP_W > IDX_W) ? DEP_W : IDX_W;
  localparam int IEXT_W = (AW > IDX_W) ? AW : IDX_W;
  localparam logic [SCMP_W-1:0] MAX_SIDE_V = SCMP_W'(MAX_SIDE);

  // ---------------------------------------------------------------- config
  logic [SIDE_W-1:0]        tex_width_r, tex_height_r;
  logic                     pixel_format_r;
  logic [CS_W-1:0]          channel_select_r;
  logic signed [TILE_W-1:0] tiling_u_r, tiling_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r      <= 9'd256;
      tex_height_r     <= 9'd256;
      pixel_format_r   <= FMT_GRAY;
      channel_select_r <= CS_RED;
      tiling_u_r       <= 21'sd65536;
      tiling_v_r       <= 21'sd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEX_WIDTH:      tex_width_r      <= cfg_data[SIDE_W-1:0];
        REG_TEX_HEIGHT:     tex_height_r     <= cfg_data[SIDE_W-1:0];
        REG_PIXEL_FORMAT:   pixel_format_r   <= cfg_data[0];
        REG_CHANNEL_SELECT: channel_select_r <= cfg_data[CS_W-1:0];
        REG_TILING_U:       tiling_u_r       <= $signed(cfg_data);
        REG_TILING_V:       tiling_v_r       <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // sides saturate at MAX_SIDE
  logic [SIDE_W-1:0] side_w, side_h;
  assign side_w = (SCMP_W'(tex_width_r) > MAX_SIDE_V) ?
                  MAX_SIDE_V[SIDE_W-1:0] : tex_width_r;
  assign side_h = (SCMP_W'(tex_height_r) > MAX_SIDE_V) ?
                  MAX_SIDE_V[SIDE_W-1:0] : tex_height_r;

  // ---------------------------------------------------------------- flow
  logic out_valid_r;
  logic adv;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && rst_n;

  tag_t tag_in;
  always_comb begin
    tag_in.valid       = in_valid && rst_n;
    tag_in.is_load     = (in_func == FUNC_LOAD);
    tag_in.pixel_index = in_pixel_index;
    tag_in.texel_word  = in_texel_word;
  end

  // ---------------------------------------------------------------- coordinates
  tag_t          mtag;
  logic [AW-1:0] raddr;

  tths_coord #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_coord (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .tag_in   (tag_in),
    .coord_u  (in_coord_u),
    .coord_v  (in_coord_v),
    .tiling_u (tiling_u_r),
    .tiling_v (tiling_v_r),
    .side_w   (side_w),
    .side_h   (side_h),
    .tag_out  (mtag),
    .addr     (raddr)
  );

  // ---------------------------------------------------------------- texel store
  // Loads write and samples read in this one stage, keeping program order.
  logic [IEXT_W-1:0] idx_ext;
  logic              idx_in_range;
  logic              ram_we, ram_re;
  logic [WORD_W-1:0] rdata;
  logic              loaded_r;
  shd_ctl_t          mctl_nxt, mctl_r;

  assign idx_ext      = IEXT_W'(mtag.pixel_index);
  assign idx_in_range = ICMP_W'(mtag.pixel_index) < ICMP_W'(STORE_DEPTH);
  assign ram_we       = adv && mtag.valid && mtag.is_load && idx_in_range;
  assign ram_re       = adv && mtag.valid && !mtag.is_load;

  tths_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_ext[AW-1:0]),
    .wdata (mtag.texel_word),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // no texture, zero side or a meaningless channel code: invalid sample
  always_comb begin
    mctl_nxt.valid = mtag.valid && !mtag.is_load;
    mctl_nxt.ok    = loaded_r && (side_w != '0) && (side_h != '0)
                     && !((pixel_format_r == FMT_BGRA) && (channel_select_r > CS_LUMA));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r     <= 1'b0;
      mctl_r.valid <= 1'b0;
    end else begin
      if (ram_we) begin
        loaded_r <= 1'b1;
      end
      if (adv) begin
        mctl_r <= mctl_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- shading
  result_t res;

  tths_shade u_shade (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .ctl            (mctl_r),
    .texel          (rdata),
    .pixel_format   (pixel_format_r),
    .channel_select (channel_select_r),
    .res            (res)
  );

  // ---------------------------------------------------------------- output
  logic [HGT_W-1:0] height_r;
  logic             sample_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      height_r       <= res.height_value;
      sample_valid_r <= res.sample_valid;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_height_value = height_r;
  assign out_sample_valid = sample_valid_r;

endmodule

FILE: sv/tths_checker.sv
// Port-level checks of the sampler core, bound to the top level.
module tths_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tths_pkg::HGT_W-1:0]   out_height_value,
  input logic                         out_sample_valid
);
  import tths_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_height_value)
                                && $stable(out_sample_valid))
    else $error("result changed while stalled");

  // an invalid sample carries a zero height
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sample_valid |-> out_height_value == '0)
    else $error("invalid sample with nonzero height");

  // a held result freezes the pipe, so no item enters
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while output stalled");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind tiled_texture_height_sampler_core tths_checker u_tths_checker (.*);

FILE: verif/tiled_texture_height_sampler_core_tb.sv
// Testbench for the tiled texture height sampler core: directed and random items.
module tiled_texture_height_sampler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tths_pkg::*;

  // Texel store and side limit of the default build
  localparam int TEXEL_DEPTH = 65536;
  localparam int SIDE_MAX    = 256;
  // Pipe is 10 deep; loads cause no result, so give them room to land
  localparam int DRAIN_CYCLES = 16;
  // Cycles with no item moving on either channel before the run is abandoned
  localparam int QUIET_LIMIT  = 2000;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 70;

  // Index with no register behind it; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic [TILE_W-1:0]  TILE_ONE  = 21'h01_0000;
  localparam logic [TILE_W-1:0]  TILE_MAX  = 21'h0F_FFFF;
  localparam logic [TILE_W-1:0]  TILE_MIN  = 21'h10_0000;
  localparam logic [TILE_W-1:0]  TILE_NEG1 = 21'h1F_0000;
  localparam logic [COORD_W-1:0] COORD_ONE = 17'd65536;
  localparam logic [COORD_W-1:0] COORD_HALF = 17'd32768;
  localparam logic [COORD_W-1:0] COORD_3Q  = 17'd49152;
  localparam logic [COORD_W-1:0] COORD_TOP = 17'h1_FFFF;

  typedef struct packed {
    logic             sample_valid;
    logic [HGT_W-1:0] height_value;
  } height_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_func = FUNC_LOAD;
  logic [IDX_W-1:0]      in_pixel_index = '0;
  logic [WORD_W-1:0]     in_texel_word = '0;
  logic [COORD_W-1:0]    in_coord_u = '0;
  logic [COORD_W-1:0]    in_coord_v = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [HGT_W-1:0]      out_height_value;
  logic                  out_sample_valid;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tiled_texture_height_sampler_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_pixel_index   (in_pixel_index),
    .in_texel_word    (in_texel_word),
    .in_coord_u       (in_coord_u),
    .in_coord_v       (in_coord_v),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_height_value (out_height_value),
    .out_sample_valid (out_sample_valid),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the block: texel store, loaded flag and register file.
  // texel_written keeps track of entries loaded since reset, so that no
  // sample is ever pointed at an entry whose content is undefined.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0]        texel_mirror [TEXEL_DEPTH];
  bit                       texel_written [TEXEL_DEPTH];
  bit                       tex_loaded = 1'b0;
  logic [SIDE_W-1:0]        m_width = 9'd256;
  logic [SIDE_W-1:0]        m_height = 9'd256;
  logic                     m_format = FMT_GRAY;
  logic [CS_W-1:0]          m_chan = CS_RED;
  logic signed [TILE_W-1:0] m_tile_u = TILE_ONE;
  logic signed [TILE_W-1:0] m_tile_v = TILE_ONE;

  height_t expected_heights[$];
  int      errors = 0;
  int      quiet_cycles = 0;
  int      burst_left = 0;
  bit      sender_gaps = 1'b1;

  // Receiver stall pattern state
  int      rx_mode = 0;
  int      rx_mode_left = 0;
  int      rx_hold = 0;
  bit      rx_phase = 1'b1;

  // Tile about one half and keep the fractional part, Q32
  function automatic logic [FRAC_W-1:0] wrap_coord(input logic [COORD_W-1:0] c,
                                                   input logic signed [TILE_W-1:0] t);
    longint prod;
    prod = (longint'(c) - 64'sd32768) * longint'(t) + 64'sh8000_0000;
    return prod[FRAC_W-1:0];
  endfunction

  // Round half up of frac * span (frac in Q32, may be exactly 1.0), clamp to span
  function automatic logic [SIDE_W-1:0] round_pixel(input logic [FRAC_W:0] frac,
                                                    input logic [SIDE_W-1:0] span);
    logic [63:0] p;
    p = (64'(frac) * 64'(span) + 64'h8000_0000) >> 32;
    if (p > 64'(span)) p = 64'(span);
    return p[SIDE_W-1:0];
  endfunction

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
    return (s > SIDE_MAX) ? SIDE_W'(SIDE_MAX) : s;
  endfunction

  function automatic bit texture_usable();
    return tex_loaded && clamp_side(m_width) != 0 && clamp_side(m_height) != 0;
  endfunction

  // Linear texel address hit by (u, v); v runs bottom up
  function automatic logic [IDX_W-1:0] texel_addr(input logic [COORD_W-1:0] u,
                                                  input logic [COORD_W-1:0] v);
    logic [SIDE_W-1:0] w, h, x, y;
    logic [FRAC_W-1:0] fu, fv;
    int unsigned       lin;
    w   = clamp_side(m_width);
    h   = clamp_side(m_height);
    fu  = wrap_coord(u, m_tile_u);
    fv  = wrap_coord(v, m_tile_v);
    x   = round_pixel({1'b0, fu}, w - 1'b1);
    y   = round_pixel(33'h1_0000_0000 - {1'b0, fv}, h - 1'b1);
    lin = 32'(y) * 32'(w) + 32'(x);
    return lin[IDX_W-1:0];
  endfunction

  function automatic height_t predict_height(input logic [COORD_W-1:0] u,
                                             input logic [COORD_W-1:0] v);
    logic [WORD_W-1:0] word;
    int unsigned       r, g, b, a, lum;
    height_t           res;
    res = '0;
    if (!texture_usable()) return res;
    word = texel_mirror[texel_addr(u, v)];
    b = 32'(word[7:0]);
    g = 32'(word[15:8]);
    r = 32'(word[23:16]);
    a = 32'(word[31:24]);
    res.sample_valid = 1'b1;
    if (m_format == FMT_GRAY) begin
      res.height_value = HGT_W'(b * LUM_SCALE);
    end else begin
      case (m_chan)
        CS_RED:   res.height_value = HGT_W'(r * LUM_SCALE);
        CS_GREEN: res.height_value = HGT_W'(g * LUM_SCALE);
        CS_BLUE:  res.height_value = HGT_W'(b * LUM_SCALE);
        CS_ALPHA: res.height_value = HGT_W'(a * LUM_SCALE);
        CS_LUMA: begin
          lum = (LUM_SCALE * (LUM_KR * r + LUM_KG * g + LUM_KB * b) + LUM_ROUND) / 10000;
          res.height_value = HGT_W'(lum);
        end
        default: res = '0;  // undefined selects give an invalid sample
      endcase
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Items go out in bursts of random length; between bursts the valid
  // drops unless sender_gaps is off. Valid is only ever raised or lowered once
  // per edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic func, input logic [IDX_W-1:0] idx,
                           input logic [WORD_W-1:0] word,
                           input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
    if (burst_left == 0) begin
      if (sender_gaps) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_func        <= func;
    in_pixel_index <= idx;
    in_texel_word  <= word;
    in_coord_u     <= u;
    in_coord_v     <= v;
    do @(posedge clk); while (!in_ready);
    // item taken at this edge; the mirror follows in order
    if (func == FUNC_LOAD) begin
      texel_mirror[idx]  = word;
      texel_written[idx] = 1'b1;
      tex_loaded         = 1'b1;
    end else begin
      expected_heights.push_back(predict_height(u, v));
    end
  endtask

  task automatic load_texel(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] word);
    send_item(FUNC_LOAD, idx, word, COORD_W'($urandom()), COORD_W'($urandom()));
  endtask

  // Sample at (u, v); a texel that was never loaded gets a random word first
  task automatic sample_at(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
    logic [IDX_W-1:0] a;
    if (texture_usable()) begin
      a = texel_addr(u, v);
      if (!texel_written[a]) load_texel(a, $urandom());
    end
    send_item(FUNC_SAMPLE, IDX_W'($urandom()), $urandom(), u, v);
  endtask

  // Stop sending, let every expected result come back and the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_heights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; bits above a narrow register carry junk the block must drop
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] bus;
    bus = value;
    case (idx)
      REG_TEX_WIDTH, REG_TEX_HEIGHT:
        bus[CFG_DATA_W-1:SIDE_W] = (CFG_DATA_W - SIDE_W)'($urandom());
      REG_PIXEL_FORMAT:
        bus[CFG_DATA_W-1:1] = (CFG_DATA_W - 1)'($urandom());
      REG_CHANNEL_SELECT:
        bus[CFG_DATA_W-1:CS_W] = (CFG_DATA_W - CS_W)'($urandom());
      default: ;
    endcase
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= bus;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TEX_WIDTH:      m_width = bus[SIDE_W-1:0];
      REG_TEX_HEIGHT:     m_height = bus[SIDE_W-1:0];
      REG_PIXEL_FORMAT:   m_format = bus[0];
      REG_CHANNEL_SELECT: m_chan = bus[CS_W-1:0];
      REG_TILING_U:       m_tile_u = bus;
      REG_TILING_V:       m_tile_v = bus;
      default: ;
    endcase
  endtask

  task automatic set_view(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                          input logic fmt, input logic [CS_W-1:0] chan,
                          input logic [TILE_W-1:0] tu, input logic [TILE_W-1:0] tv);
    write_reg(REG_TEX_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_TEX_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(fmt));
    write_reg(REG_CHANNEL_SELECT, CFG_DATA_W'(chan));
    write_reg(REG_TILING_U, tu);
    write_reg(REG_TILING_V, tv);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and receiver stall pattern. The receiver cycles through
  // three moods: always ready, sparse random stalls, and on/off runs.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    height_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_heights.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: height %0d sample_valid %0b",
                   $time, out_height_value, out_sample_valid);
        end else begin
          want = expected_heights.pop_front();
          if (out_height_value !== want.height_value) begin
            errors++;
            $display("%0t: height_value mismatch: expected %0d actual %0d",
                     $time, want.height_value, out_height_value);
          end
          if (out_sample_valid !== want.sample_valid) begin
            errors++;
            $display("%0t: sample_valid mismatch: expected %0b actual %0b",
                     $time, want.sample_valid, out_sample_valid);
          end
        end
      end
      quiet_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ?
                      0 : quiet_cycles + 1;

      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(50, 400);
      end
      rx_mode_left--;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (rx_hold == 0) begin
            rx_phase = !rx_phase;
            rx_hold  = $urandom_range(1, 8);
          end
          rx_hold--;
          out_ready <= rx_phase;
        end
      endcase
    end
  end

  // Watchdog: nothing moving on either channel for too long ends the run
  initial begin
    @(posedge rst_n);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Nothing loaded yet: every sample is invalid with a zero height
  task automatic test_unloaded();
    sample_at('0, '0);
    sample_at(COORD_TOP, COORD_TOP);
    sample_at(COORD_ONE, COORD_HALF);
  endtask

  // 2x2 B G R A texture, every channel select including the undefined ones.
  // With unit tiling (3/4, 0) hits texel 3, (0, 3/4) texel 0, (3/4, 3/4) texel 1.
  task automatic test_channels();
    int c;
    settle();
    set_view(9'd2, 9'd2, FMT_BGRA, CS_RED, TILE_ONE, TILE_ONE);
    load_texel(16'd0, 32'hFFFF_FFFF);
    load_texel(16'd1, 32'h0000_0000);
    load_texel(16'd2, 32'h1234_5678);
    load_texel(16'd3, 32'h80C0_E0F0);
    for (c = 0; c < (1 << CS_W); c++) begin
      if (c != 0) begin
        settle();
        write_reg(REG_CHANNEL_SELECT, CFG_DATA_W'(c));
      end
      sample_at(COORD_3Q, '0);
      if (c == CS_LUMA) begin
        // white and black luminance ends
        sample_at('0, COORD_3Q);
        sample_at(COORD_3Q, COORD_3Q);
      end
    end
  endtask

  // Zero side, saturated sides, one-pixel texture and extreme tiling
  task automatic test_sides_and_tiling();
    settle();
    set_view(9'd0, 9'd4, FMT_GRAY, CS_RED, TILE_ONE, TILE_ONE);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    sample_at(COORD_HALF, COORD_HALF);
    settle();
    // gray ignores the select; sides above the limit saturate
    set_view(9'd511, 9'd257, FMT_GRAY, CS_LUMA, TILE_MAX, TILE_MIN);
    sample_at('0, '0);
    sample_at(COORD_ONE, COORD_TOP);
    sample_at(COORD_TOP, COORD_HALF);
    settle();
    set_view(9'd1, 9'd1, FMT_BGRA, CS_ALPHA, '0, TILE_NEG1);
    sample_at(17'd12345, 17'd54321);
  endtask

  function automatic logic [SIDE_W-1:0] rand_side();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return SIDE_W'(SIDE_MAX);
    if (r == 2) return SIDE_W'($urandom_range(SIDE_MAX + 1, 511));
    if (r <= 5) return SIDE_W'($urandom_range(17, SIDE_MAX - 1));
    return SIDE_W'($urandom_range(1, 16));
  endfunction

  function automatic logic [TILE_W-1:0] rand_tiling();
    int k;
    case ($urandom_range(0, 7))
      0: return TILE_MIN;
      1: return TILE_MAX;
      2: return TILE_W'($urandom());
      3: return '0;
      default: begin
        // mostly whole and half repeats from -4 to 4 with a little jitter
        k = int'($urandom_range(0, 16)) - 8;
        return TILE_W'(k * 32768 + int'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return COORD_W'($urandom_range(0, 131071));
    return COORD_W'($urandom_range(0, 65536));
  endfunction

  // Random phases: fresh settings, then a mix of loads and samples. Loads
  // mostly land inside the current texture so samples read fresh data.
  task automatic test_random_phases();
    int p, n, area;
    logic [CS_W-1:0] chan;
    for (p = 0; p < RAND_PHASES; p++) begin
      settle();
      chan = ($urandom_range(0, 5) == 0) ? CS_W'($urandom_range(5, 7))
                                         : CS_W'($urandom_range(0, 4));
      set_view(rand_side(), rand_side(), logic'($urandom_range(0, 1)), chan,
               rand_tiling(), rand_tiling());
      sender_gaps = ($urandom_range(0, 3) != 0);
      area = int'(clamp_side(m_width)) * int'(clamp_side(m_height));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) < 3) begin
          if (area == 0 || $urandom_range(0, 7) == 0)
            load_texel(IDX_W'($urandom()), $urandom());
          else
            load_texel(IDX_W'($urandom_range(0, area - 1)), $urandom());
        end else begin
          sample_at(rand_coord(), rand_coord());
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unloaded();
    test_channels();
    test_sides_and_tiling();
    test_random_phases();
    settle();
    if (errors == 0 && expected_heights.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
